@@ rtl/core/pgv_pkg.sv @@
package pgv_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned DIFF_W = WORD_W + 1;
    localparam int unsigned ROOT_W = DIFF_W;
    localparam int unsigned SQ_W   = 2 * ROOT_W;
    localparam int unsigned K_W    = 2 * WORD_W;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned NUM_W  = K_W + DIFF_W + FRAC_W;
    localparam int unsigned DEN_W  = SQ_W + ROOT_W;
    localparam int unsigned Q_W    = DIFF_W + 1;
    localparam int unsigned SUM_W  = Q_W + 1;

    localparam logic [WORD_W-1:0] GRAV_RESET = WORD_W'(294912);

    // largest step magnitude, 2^33
    localparam logic [Q_W-1:0] Q_CAP = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic              sx;
        logic              sy;
        logic              dyn;
        logic              zero;
        logic [WORD_W-1:0] vx;
        logic [WORD_W-1:0] vy;
    } side_t;

    typedef struct packed {
        logic [WORD_W-1:0] new_vel_x;
        logic [WORD_W-1:0] new_vel_y;
        logic              coincident;
        logic              saturated;
    } res_t;

endpackage

@@ rtl/core/pgv_pair_if.sv @@
interface pgv_pair_if;
    logic                        valid;
    logic                        ready;
    logic [pgv_pkg::WORD_W-1:0]  self_pos_x;
    logic [pgv_pkg::WORD_W-1:0]  self_pos_y;
    logic [pgv_pkg::WORD_W-1:0]  other_pos_x;
    logic [pgv_pkg::WORD_W-1:0]  other_pos_y;
    logic [pgv_pkg::WORD_W-1:0]  self_mass;
    logic [pgv_pkg::WORD_W-1:0]  other_mass;
    logic [pgv_pkg::WORD_W-1:0]  self_vel_x;
    logic [pgv_pkg::WORD_W-1:0]  self_vel_y;
    logic                        self_dynamic;

    modport source (
        output valid, self_pos_x, self_pos_y, other_pos_x, other_pos_y,
               self_mass, other_mass, self_vel_x, self_vel_y, self_dynamic,
        input  ready
    );
    modport sink (
        input  valid, self_pos_x, self_pos_y, other_pos_x, other_pos_y,
               self_mass, other_mass, self_vel_x, self_vel_y, self_dynamic,
        output ready
    );
endinterface

@@ rtl/core/pgv_result_if.sv @@
interface pgv_result_if;
    logic                        valid;
    logic                        ready;
    logic [pgv_pkg::WORD_W-1:0]  new_vel_x;
    logic [pgv_pkg::WORD_W-1:0]  new_vel_y;
    logic                        coincident;
    logic                        saturated;

    modport source (
        output valid, new_vel_x, new_vel_y, coincident, saturated,
        input  ready
    );
    modport sink (
        input  valid, new_vel_x, new_vel_y, coincident, saturated,
        output ready
    );
endinterface

@@ rtl/core/pgv_div_pipe.sv @@
// restoring divider, one quotient bit per stage, with an up-front overflow check
module pgv_div_pipe #(
    parameter int unsigned NUM_W = pgv_pkg::NUM_W,
    parameter int unsigned DEN_W = pgv_pkg::DEN_W,
    parameter int unsigned Q_W   = pgv_pkg::Q_W
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quot,
    output logic             ovf
);

    localparam int unsigned CMP_W = DEN_W + Q_W;

    logic [NUM_W-1:0] rem_reg  [0:Q_W];
    logic [DEN_W-1:0] den_reg  [0:Q_W];
    logic [Q_W-1:0]   q_reg    [0:Q_W];
    logic             ovf_reg  [0:Q_W];
    logic [NUM_W-1:0] rem_next [0:Q_W-1];
    logic [Q_W-1:0]   q_next   [0:Q_W-1];

    // quotient would not fit in Q_W bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (CMP_W'(num) >= {den, {Q_W{1'b0}}});
        end
    end

    for (genvar j = 0; j < Q_W; j++)
    begin : g_step
        localparam int unsigned SH = Q_W - 1 - j;
        logic [CMP_W-1:0] shifted;
        logic             ge;

        always_comb
        begin
            shifted     = CMP_W'(den_reg[j]) << SH;
            ge          = (CMP_W'(rem_reg[j]) >= shifted);
            rem_next[j] = ge ? (rem_reg[j] - shifted[NUM_W-1:0]) : rem_reg[j];
            q_next[j]   = q_reg[j] | (Q_W'(ge) << SH);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= rem_next[j];
                den_reg[j+1] <= den_reg[j];
                q_reg[j+1]   <= q_next[j];
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
    end

    assign quot = q_reg[Q_W];
    assign ovf  = ovf_reg[Q_W];

endmodule

@@ rtl/core/pairwise_gravity_velocity_update.sv @@
// channel   | dir | beat contents
// ----------+-----+---------------------------------------------------------
// pair      | in  | both positions, both masses, self velocity, dynamic flag
// result    | out | new velocity x/y, coincident, saturated
// grav_const| in  | write enable + 32-bit data, unsigned Q16.16
//
// one pair per cycle sustained while the skid is empty
// depth set by the 33-step square root and the 34-step restoring divider
// rst_n clears valid bits, skid and grav_const (to 4.5); datapath has no reset
// a stalled result parks in a one-beat skid; the pipe freezes only while it is full
module pairwise_gravity_velocity_update (
    input  logic                         clk,
    input  logic                         rst_n,
    pgv_pair_if.sink                     pair,
    pgv_result_if.source                 result,
    input  logic                         grav_const_we,
    input  logic [pgv_pkg::WORD_W-1:0]   grav_const_wdata
);

    localparam int unsigned WORD_W = pgv_pkg::WORD_W;
    localparam int unsigned DIFF_W = pgv_pkg::DIFF_W;
    localparam int unsigned ROOT_W = pgv_pkg::ROOT_W;
    localparam int unsigned SQ_W   = pgv_pkg::SQ_W;
    localparam int unsigned K_W    = pgv_pkg::K_W;
    localparam int unsigned FRAC_W = pgv_pkg::FRAC_W;
    localparam int unsigned NUM_W  = pgv_pkg::NUM_W;
    localparam int unsigned DEN_W  = pgv_pkg::DEN_W;
    localparam int unsigned Q_W    = pgv_pkg::Q_W;
    localparam int unsigned SUM_W  = pgv_pkg::SUM_W;
    localparam int unsigned HALF_W = K_W / 2;
    localparam int unsigned KP_W   = HALF_W + DIFF_W;
    localparam int unsigned SLO_W  = SQ_W / 2;

    // stage map
    localparam int unsigned ST_A   = 0;                  // differences
    localparam int unsigned ST_B   = 1;                  // squares, G*m2
    localparam int unsigned ST_C   = 2;                  // sum of squares, k*|d| halves
    localparam int unsigned ST_D   = 3;                  // numerators
    localparam int unsigned ST_SQ0 = 4;                  // square root steps
    localparam int unsigned ST_E   = ST_SQ0 + ROOT_W;    // S*R halves
    localparam int unsigned ST_F   = ST_E + 1;           // S*R
    localparam int unsigned ST_OUT = ST_F + Q_W + 2;     // after divider
    localparam int unsigned NST    = ST_OUT + 1;

    logic                en;
    logic [NST-1:0]      v_reg;
    logic [WORD_W-1:0]   grav_reg;

    pgv_pkg::side_t      side_reg  [0:ST_OUT-1];
    pgv_pkg::side_t      side_next [0:ST_OUT-1];

    // stage A
    logic [DIFF_W-1:0]   a_dx_reg, a_dy_reg;
    logic [WORD_W-1:0]   a_m2_reg;
    // stage B
    logic [DIFF_W-1:0]   b_ax_reg, b_ay_reg, b_ax_next, b_ay_next;
    logic [SQ_W-1:0]     b_ax2_reg, b_ay2_reg;
    logic [K_W-1:0]      b_k_reg;
    // stage C
    logic [SQ_W-1:0]     c_s_reg;
    logic [KP_W-1:0]     c_kxl_reg, c_kxh_reg, c_kyl_reg, c_kyh_reg;
    // stage D
    logic [SQ_W-1:0]     d_s_reg;
    logic [NUM_W-1:0]    d_numx_reg, d_numy_reg;
    // square root steps
    logic [SQ_W-1:0]     sq_rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0]   sq_res_reg  [0:ROOT_W-1];
    logic [SQ_W-1:0]     sq_s_reg    [0:ROOT_W-1];
    logic [NUM_W-1:0]    sq_numx_reg [0:ROOT_W-1];
    logic [NUM_W-1:0]    sq_numy_reg [0:ROOT_W-1];
    logic [SQ_W-1:0]     sq_rem_next [0:ROOT_W-1];
    logic [ROOT_W-1:0]   sq_res_next [0:ROOT_W-1];
    // stage E, F
    logic [SQ_W-1:0]     e_plo_reg, e_phi_reg;
    logic [NUM_W-1:0]    e_numx_reg, e_numy_reg;
    logic [DEN_W-1:0]    f_den_reg;
    logic [NUM_W-1:0]    f_numx_reg, f_numy_reg;
    // divider outputs
    logic [Q_W-1:0]      qx, qy;
    logic                ovfx, ovfy;
    // output and skid
    pgv_pkg::res_t       out_reg, out_next, skid_reg;
    logic                skid_v_reg;

    // one axis: apply step of magnitude q with sign neg, clamp to 32 bits
    function automatic logic [WORD_W:0] axis_apply(
        input logic [WORD_W-1:0] vel,
        input logic              neg,
        input logic [Q_W-1:0]    q,
        input logic              ovf
    );
        logic [Q_W-1:0]   qm;
        logic [SUM_W-1:0] vext;
        logic [SUM_W-1:0] qext;
        logic [SUM_W-1:0] sum;
        logic             fits;
        logic [WORD_W-1:0] val;
        qm   = (ovf || (q > pgv_pkg::Q_CAP)) ? pgv_pkg::Q_CAP : q;
        vext = {{(SUM_W-WORD_W){vel[WORD_W-1]}}, vel};
        qext = {{(SUM_W-Q_W){1'b0}}, qm};
        sum  = neg ? (vext - qext) : (vext + qext);
        fits = (sum[SUM_W-1:WORD_W-1] == '0) || (sum[SUM_W-1:WORD_W-1] == '1);
        if (fits)
        begin
            val = sum[WORD_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            val = {1'b1, {(WORD_W-1){1'b0}}};
        end
        else
        begin
            val = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return {!fits, val};
    endfunction

    // pipe advances whenever the skid is empty
    assign en         = !skid_v_reg;
    assign pair.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg <= pgv_pkg::GRAV_RESET;
        end
        else if (grav_const_we)
        begin
            grav_reg <= grav_const_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], pair.valid};
        end
    end

    // sideband shift line; coincidence is known once the sum of squares exists
    always_comb
    begin
        side_next[0].sx   = 1'b0;
        side_next[0].sy   = 1'b0;
        side_next[0].dyn  = pair.self_dynamic;
        side_next[0].zero = 1'b0;
        side_next[0].vx   = pair.self_vel_x;
        side_next[0].vy   = pair.self_vel_y;
        for (int i = 1; i < ST_OUT; i++)
        begin
            side_next[i] = side_reg[i-1];
        end
        side_next[ST_B].sx   = a_dx_reg[DIFF_W-1];
        side_next[ST_B].sy   = a_dy_reg[DIFF_W-1];
        side_next[ST_D].zero = (c_s_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ST_OUT; i++)
            begin
                side_reg[i] <= side_next[i];
            end
        end
    end

    // separations and absolute values
    always_comb
    begin
        b_ax_next = a_dx_reg[DIFF_W-1] ? (DIFF_W'(0) - a_dx_reg) : a_dx_reg;
        b_ay_next = a_dy_reg[DIFF_W-1] ? (DIFF_W'(0) - a_dy_reg) : a_dy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage A
            a_dx_reg <= {pair.other_pos_x[WORD_W-1], pair.other_pos_x}
                      - {pair.self_pos_x[WORD_W-1], pair.self_pos_x};
            a_dy_reg <= {pair.other_pos_y[WORD_W-1], pair.other_pos_y}
                      - {pair.self_pos_y[WORD_W-1], pair.self_pos_y};
            a_m2_reg <= pair.other_mass;
            // stage B
            b_ax_reg  <= b_ax_next;
            b_ay_reg  <= b_ay_next;
            b_ax2_reg <= SQ_W'(b_ax_next) * SQ_W'(b_ax_next);
            b_ay2_reg <= SQ_W'(b_ay_next) * SQ_W'(b_ay_next);
            b_k_reg   <= K_W'(grav_reg) * K_W'(a_m2_reg);
            // stage C: k*|d| split over the halves of k
            c_s_reg   <= b_ax2_reg + b_ay2_reg;
            c_kxl_reg <= KP_W'(b_k_reg[HALF_W-1:0]) * KP_W'(b_ax_reg);
            c_kxh_reg <= KP_W'(b_k_reg[K_W-1:HALF_W]) * KP_W'(b_ax_reg);
            c_kyl_reg <= KP_W'(b_k_reg[HALF_W-1:0]) * KP_W'(b_ay_reg);
            c_kyh_reg <= KP_W'(b_k_reg[K_W-1:HALF_W]) * KP_W'(b_ay_reg);
            // stage D: numerator = k*|d|*2^16
            d_s_reg    <= c_s_reg;
            d_numx_reg <= ((NUM_W'(c_kxh_reg) << HALF_W) + NUM_W'(c_kxl_reg)) << FRAC_W;
            d_numy_reg <= ((NUM_W'(c_kyh_reg) << HALF_W) + NUM_W'(c_kyl_reg)) << FRAC_W;
        end
    end

    // integer square root, one result bit per stage, msb first
    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_root
        localparam int unsigned B = ROOT_W - 1 - j;
        logic [SQ_W:0]     trial;
        logic [SQ_W-1:0]   rem_in;
        logic [ROOT_W-1:0] res_in;
        logic [SQ_W-1:0]   s_in;
        logic [NUM_W-1:0]  numx_in;
        logic [NUM_W-1:0]  numy_in;
        logic              ge;

        if (j == 0)
        begin : g_first
            assign rem_in  = d_s_reg;
            assign res_in  = '0;
            assign s_in    = d_s_reg;
            assign numx_in = d_numx_reg;
            assign numy_in = d_numy_reg;
        end
        else
        begin : g_rest
            assign rem_in  = sq_rem_reg[j-1];
            assign res_in  = sq_res_reg[j-1];
            assign s_in    = sq_s_reg[j-1];
            assign numx_in = sq_numx_reg[j-1];
            assign numy_in = sq_numy_reg[j-1];
        end

        // (res + 2^b)^2 - res^2 = res*2^(b+1) + 2^(2b)
        always_comb
        begin
            trial          = ((SQ_W+1)'(res_in) << (B + 1)) | ((SQ_W+1)'(1) << (2 * B));
            ge             = ((SQ_W+1)'(rem_in) >= trial);
            sq_rem_next[j] = ge ? (rem_in - trial[SQ_W-1:0]) : rem_in;
            sq_res_next[j] = res_in | (ROOT_W'(ge) << B);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[j]  <= sq_rem_next[j];
                sq_res_reg[j]  <= sq_res_next[j];
                sq_s_reg[j]    <= s_in;
                sq_numx_reg[j] <= numx_in;
                sq_numy_reg[j] <= numy_in;
            end
        end
    end

    // distance cubed as S*R, S split into two halves
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_plo_reg  <= SQ_W'(sq_s_reg[ROOT_W-1][SLO_W-1:0]) * SQ_W'(sq_res_reg[ROOT_W-1]);
            e_phi_reg  <= SQ_W'(sq_s_reg[ROOT_W-1][SQ_W-1:SLO_W]) * SQ_W'(sq_res_reg[ROOT_W-1]);
            e_numx_reg <= sq_numx_reg[ROOT_W-1];
            e_numy_reg <= sq_numy_reg[ROOT_W-1];
            f_den_reg  <= (DEN_W'(e_phi_reg) << SLO_W) + DEN_W'(e_plo_reg);
            f_numx_reg <= e_numx_reg;
            f_numy_reg <= e_numy_reg;
        end
    end

    pgv_div_pipe #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .Q_W   (Q_W)
    ) u_div_x (
        .clk  (clk),
        .en   (en),
        .num  (f_numx_reg),
        .den  (f_den_reg),
        .quot (qx),
        .ovf  (ovfx)
    );

    pgv_div_pipe #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .Q_W   (Q_W)
    ) u_div_y (
        .clk  (clk),
        .en   (en),
        .num  (f_numy_reg),
        .den  (f_den_reg),
        .quot (qy),
        .ovf  (ovfy)
    );

    // final add, clamp, and pass-through for fixed or coincident bodies
    always_comb
    begin
        logic [WORD_W:0] ax_res;
        logic [WORD_W:0] ay_res;
        pgv_pkg::side_t  sd;
        sd     = side_reg[ST_OUT-1];
        ax_res = axis_apply(sd.vx, sd.sx, qx, ovfx);
        ay_res = axis_apply(sd.vy, sd.sy, qy, ovfy);
        if (!sd.dyn || sd.zero)
        begin
            out_next.new_vel_x  = sd.vx;
            out_next.new_vel_y  = sd.vy;
            out_next.coincident = sd.dyn;
            out_next.saturated  = 1'b0;
        end
        else
        begin
            out_next.new_vel_x  = ax_res[WORD_W-1:0];
            out_next.new_vel_y  = ay_res[WORD_W-1:0];
            out_next.coincident = 1'b0;
            out_next.saturated  = ax_res[WORD_W] | ay_res[WORD_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    // skid: catches the output beat when the pipe moves under a stalled sink
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (result.ready)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (v_reg[ST_OUT] && !result.ready)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_v_reg && v_reg[ST_OUT] && !result.ready)
        begin
            skid_reg <= out_reg;
        end
    end

    assign result.valid      = skid_v_reg | v_reg[ST_OUT];
    assign result.new_vel_x  = skid_v_reg ? skid_reg.new_vel_x  : out_reg.new_vel_x;
    assign result.new_vel_y  = skid_v_reg ? skid_reg.new_vel_y  : out_reg.new_vel_y;
    assign result.coincident = skid_v_reg ? skid_reg.coincident : out_reg.coincident;
    assign result.saturated  = skid_v_reg ? skid_reg.saturated  : out_reg.saturated;

endmodule
